@@ hdl/psd_pkg.sv @@
`default_nettype none
package psd_pkg;
    // Coordinate and derived widths
    localparam int CoordW = 16;
    localparam int DiffW  = 17;      // B - A, P - A
    localparam int SqW    = 35;      // |d|^2, always >= 0
    localparam int NumW   = 36;      // d . (P - A), signed
    localparam int TW     = 17;      // t in Q1.16, 65536 = 1
    localparam int FracW  = 16;      // quotient bits from the divider
    localparam int ErrW   = 38;      // offset component in 2^-20 units, signed
    localparam int MagW   = 25;      // magnitude in Q.8
    localparam int SumW   = 51;      // sum of squared magnitudes
    localparam int RadW   = 44;      // radicand = sum >> 8, padded to an even width
    localparam int DistW  = 17;
    localparam int DIV_CELLS  = FracW;
    localparam int SQRT_CELLS = 22;  // RadW / 2
    localparam int InW  = 6 * CoordW;
    localparam int OutW = 40;        // 35 bits packed, padded to bytes

    // Values handed from the setup stage down the divider row
    typedef struct packed {
        logic signed [DiffW-1:0] rx;
        logic signed [DiffW-1:0] ry;
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic                    degen;
        logic                    sat_lo;
        logic                    sat_hi;
    } psd_geo_t;
endpackage
`default_nettype wire

@@ hdl/psd_div_cell.sv @@
`default_nettype none
// One restoring division step: produce one quotient bit per cell.
module psd_div_cell
    import psd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [SqW:0]       rem_in,
    input  wire logic [SqW-1:0]     den_in,
    input  wire logic [FracW-1:0]   q_in,
    input  wire psd_geo_t           geo_in,
    output logic [SqW:0]            rem_out,
    output logic [SqW-1:0]          den_out,
    output logic [FracW-1:0]        q_out,
    output psd_geo_t                geo_out
);
    logic [SqW+1:0] shifted;
    logic [SqW+1:0] diff;
    logic           take;

    // Shift the partial remainder and try to subtract the divisor
    always_comb begin
        shifted = {rem_in, 1'b0};
        diff    = shifted - {2'b00, den_in};
        take    = (shifted >= {2'b00, den_in});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= take ? diff[SqW:0] : shifted[SqW:0];
            den_out <= den_in;
            q_out   <= {q_in[FracW-2:0], take};
            geo_out <= geo_in;
        end
    end
endmodule
`default_nettype wire

@@ hdl/psd_sqrt_cell.sv @@
`default_nettype none
// One digit-by-digit square root step: produce one root bit per cell.
module psd_sqrt_cell
    import psd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [RadW-1:0]  rad_in,
    input  wire logic [RadW-1:0]  rem_in,
    input  wire logic [DistW+5:0] root_in,
    input  wire logic [TW:0]      side_in,
    output logic [RadW-1:0]       rad_out,
    output logic [RadW-1:0]       rem_out,
    output logic [DistW+5:0]      root_out,
    output logic [TW:0]           side_out
);
    logic [RadW+1:0] acc;
    logic [RadW+1:0] trial;
    logic            take;

    // Bring down two radicand bits and try root*4+1
    always_comb begin
        acc   = {rem_in, rad_in[RadW-1:RadW-2]};
        trial = {root_in, 2'b01};
        take  = (acc >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_out  <= {rad_in[RadW-3:0], 2'b00};
            rem_out  <= take ? RadW'(acc - trial) : acc[RadW-1:0];
            root_out <= {root_in[DistW+4:0], take};
            side_out <= side_in;
        end
    end
endmodule
`default_nettype wire

@@ hdl/point_segment_distance.sv @@
`default_nettype none
// Point to segment distance, fully pipelined.
// Input stream s_axis: one word per query holding P, A, B as signed Q12.4.
// Output stream m_axis: distance (Q.4), clamped t (Q1.16) and a flag set
// for a zero-length segment.
// Throughput: one word per cycle unless the receiver stalls. The word
// passes 43 registers: setup, 16 divider cells, clamp, multiply,
// square/sum, 22 root cells and the output register; the setup register
// loads at the accepting edge.
// The whole pipeline advances together; when the receiver holds m_tready
// low with a word shown, the pipeline freezes and s_tready stays low until
// that word is taken, so a stalled receiver never loses a result. An empty
// output slot never stalls the input.
// Reset clears all stage valid bits; payload registers are not reset.
// There is no configuration.
module point_segment_distance
    import psd_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y (16 bits each)
    input  wire logic [InW-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    // distance[16:0], position_along[33:17], degenerate[34], zero pad
    output logic [OutW-1:0]      m_tdata
);
    localparam int Stages = DIV_CELLS + SQRT_CELLS + 4;

    logic [Stages:0] vld_reg;
    logic            adv;

    // Advance when the output slot is empty or being drained
    assign adv      = !vld_reg[Stages] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[Stages];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Stages-1:0], s_tvalid};
        end
    end

    // Setup: differences, squared length, dot product
    logic signed [CoordW-1:0]  px, py, ax, ay, bx, by;
    logic signed [DiffW-1:0]   dx, dy, rx, ry;
    logic signed [2*DiffW-1:0] dd_x, dd_y, dr_x, dr_y;
    logic signed [NumW-1:0]    num;
    logic [SqW-1:0]            len2;
    assign {by, bx, ay, ax, py, px} = s_tdata;
    always_comb begin
        dx   = DiffW'(bx) - DiffW'(ax);
        dy   = DiffW'(by) - DiffW'(ay);
        rx   = DiffW'(px) - DiffW'(ax);
        ry   = DiffW'(py) - DiffW'(ay);
        dd_x = dx * dx;
        dd_y = dy * dy;
        dr_x = dx * rx;
        dr_y = dy * ry;
        len2 = SqW'(dd_x) + SqW'(dd_y);
        num  = NumW'(dr_x) + NumW'(dr_y);
    end

    logic [SqW:0]   rem_reg  [DIV_CELLS+1];
    logic [SqW-1:0] den_reg  [DIV_CELLS+1];
    logic [FracW-1:0] q_reg  [DIV_CELLS+1];
    psd_geo_t       geo_reg  [DIV_CELLS+1];

    // Register setup; saturating cases feed a zero numerator
    always_ff @(posedge aclk) begin
        if (adv) begin
            geo_reg[0].rx     <= rx;
            geo_reg[0].ry     <= ry;
            geo_reg[0].dx     <= dx;
            geo_reg[0].dy     <= dy;
            geo_reg[0].degen  <= (len2 == '0);
            geo_reg[0].sat_lo <= (len2 == '0) || (num <= 0);
            geo_reg[0].sat_hi <= (len2 != '0) && (num > 0) && (num >= $signed({1'b0, len2}));
            rem_reg[0] <= (num > 0 && num < $signed({1'b0, len2})) ?
                          (SqW+1)'(num) : '0;
            den_reg[0] <= (len2 == '0) ? SqW'(1) : len2;
            q_reg[0]   <= '0;
        end
    end

    // Divider row
    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
        psd_div_cell u_cell (
            .aclk    (aclk),
            .en      (adv),
            .rem_in  (rem_reg[i]),
            .den_in  (den_reg[i]),
            .q_in    (q_reg[i]),
            .geo_in  (geo_reg[i]),
            .rem_out (rem_reg[i+1]),
            .den_out (den_reg[i+1]),
            .q_out   (q_reg[i+1]),
            .geo_out (geo_reg[i+1])
        );
    end

    // Clamp t
    psd_geo_t       g_c_reg;
    logic [TW-1:0]  t_c_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_c_reg <= geo_reg[DIV_CELLS];
            if (geo_reg[DIV_CELLS].sat_hi) begin
                t_c_reg <= TW'(1) << FracW;
            end else if (geo_reg[DIV_CELLS].sat_lo) begin
                t_c_reg <= '0;
            end else begin
                t_c_reg <= {1'b0, q_reg[DIV_CELLS]};
            end
        end
    end

    // Offset components in 2^-20 units
    logic signed [ErrW-1:0]     ex_reg, ey_reg;
    logic [TW-1:0]              t_m_reg;
    logic                       dg_m_reg;
    logic signed [TW:0]         ts;
    logic signed [DiffW+TW:0]   dtx, dty;
    assign ts = {1'b0, t_c_reg};
    always_comb begin
        dtx = g_c_reg.dx * ts;
        dty = g_c_reg.dy * ts;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            ex_reg   <= (ErrW'(g_c_reg.rx) <<< FracW) - ErrW'(dtx);
            ey_reg   <= (ErrW'(g_c_reg.ry) <<< FracW) - ErrW'(dty);
            t_m_reg  <= t_c_reg;
            dg_m_reg <= g_c_reg.degen;
        end
    end

    // Magnitudes in Q.8, squared and summed
    logic [ErrW-1:0] ax_abs, ay_abs;
    logic [MagW-1:0] mx, my;
    assign ax_abs = ex_reg[ErrW-1] ? ErrW'(-ex_reg) : ex_reg;
    assign ay_abs = ey_reg[ErrW-1] ? ErrW'(-ey_reg) : ey_reg;
    assign mx = ax_abs[MagW+11:12];
    assign my = ay_abs[MagW+11:12];

    logic [RadW-1:0]  rad_reg  [SQRT_CELLS+1];
    logic [RadW-1:0]  srem_reg [SQRT_CELLS+1];
    logic [DistW+5:0] root_reg [SQRT_CELLS+1];
    logic [TW:0]      side_reg [SQRT_CELLS+1];
    logic [2*MagW-1:0] sq_x, sq_y;
    logic [SumW-1:0]  sum;
    always_comb begin
        sq_x = mx * mx;
        sq_y = my * my;
        sum  = SumW'(sq_x) + SumW'(sq_y);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg[0]  <= {1'b0, sum[SumW-1:8]};
            srem_reg[0] <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= {dg_m_reg, t_m_reg};
        end
    end

    // Square root row
    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        psd_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (adv),
            .rad_in   (rad_reg[j]),
            .rem_in   (srem_reg[j]),
            .root_in  (root_reg[j]),
            .side_in  (side_reg[j]),
            .rad_out  (rad_reg[j+1]),
            .rem_out  (srem_reg[j+1]),
            .root_out (root_reg[j+1]),
            .side_out (side_reg[j+1])
        );
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata <= {5'b0, side_reg[SQRT_CELLS],
                        root_reg[SQRT_CELLS][DistW-1:0]};
        end
    end

    // Output word must hold while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed under stall");
    // Degenerate segments always report t of zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[33:17] == '0)
        else $error("degenerate word with nonzero t");
    // t never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:17] <= 17'd65536)
        else $error("t out of range");
endmodule
`default_nettype wire
